@@ rtl/gpdir_pkg.sv @@
// Shared types, codes and the hat direction table for the gamepad direction decoder.
`default_nettype none

package gpdir_pkg;

	// Event kinds carried in the action field.
	localparam logic [1:0] ACT_BUTTON = 2'd0;
	localparam logic [1:0] ACT_AXIS   = 2'd1;
	localparam logic [1:0] ACT_HAT    = 2'd2;
	localparam logic [1:0] ACT_OTHER  = 2'd3;

	// Direction bits.
	localparam logic [3:0] DIR_NONE  = 4'h0;
	localparam logic [3:0] DIR_UP    = 4'h1;
	localparam logic [3:0] DIR_DOWN  = 4'h2;
	localparam logic [3:0] DIR_LEFT  = 4'h4;
	localparam logic [3:0] DIR_RIGHT = 4'h8;

	// Register indexes on the configuration port (word address bits).
	localparam logic [1:0] REG_BUTTON_OFFSETS = 2'd0;
	localparam logic [1:0] REG_AXIS_OFFSETS   = 2'd1;
	localparam logic [1:0] REG_CONNECTED_MASK = 2'd2;

	localparam int ADDR_W = 4;

	typedef struct packed {
		logic [1:0]         action;
		logic [1:0]         pad;
		logic [7:0]         raw_index;
		logic signed [15:0] raw_value;
	} evt_t;

	typedef struct packed {
		logic [1:0]  pad_out;
		logic [20:0] button_bits;
		logic [3:0]  direction;
		logic        bad_index;
	} res_t;

	typedef struct packed {
		logic [31:0] button_offsets;
		logic [31:0] axis_offsets;
		logic [3:0]  connected_mask;
	} cfg_t;

	// Eight-way hat table; positions above eight never reach it.
	function automatic logic [3:0] hat_dir(input logic [3:0] pos);
		logic [3:0] d;
		case (pos)
			4'd0: d = DIR_NONE;
			4'd1: d = DIR_UP;
			4'd2: d = DIR_UP | DIR_RIGHT;
			4'd3: d = DIR_RIGHT;
			4'd4: d = DIR_DOWN | DIR_RIGHT;
			4'd5: d = DIR_DOWN;
			4'd6: d = DIR_DOWN | DIR_LEFT;
			4'd7: d = DIR_LEFT;
			4'd8: d = DIR_LEFT | DIR_UP;
			default: d = DIR_NONE;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

@@ rtl/gpdir_cfg.sv @@
// APB-style configuration registers of the gamepad direction decoder.
`default_nettype none

module gpdir_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [gpdir_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output gpdir_pkg::cfg_t                   cfg
);

	gpdir_pkg::cfg_t cfg_q;
	logic            wr_en;
	logic [1:0]      reg_sel;

	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				gpdir_pkg::REG_BUTTON_OFFSETS: cfg_q.button_offsets <= pwdata;
				gpdir_pkg::REG_AXIS_OFFSETS:   cfg_q.axis_offsets   <= pwdata;
				gpdir_pkg::REG_CONNECTED_MASK: cfg_q.connected_mask <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			gpdir_pkg::REG_BUTTON_OFFSETS: prdata = cfg_q.button_offsets;
			gpdir_pkg::REG_AXIS_OFFSETS:   prdata = cfg_q.axis_offsets;
			gpdir_pkg::REG_CONNECTED_MASK: prdata = {28'd0, cfg_q.connected_mask};
			default:                       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/gpdir_decode.sv @@
// Per-event decode: next pad state and the result item for one registered event.
`default_nettype none

module gpdir_decode #(
	parameter int PAD_COUNT    = 4,
	parameter int BUTTON_COUNT = 21
) (
	input  wire gpdir_pkg::evt_t          evt,
	input  wire gpdir_pkg::cfg_t          cfg,
	input  wire logic [BUTTON_COUNT-1:0]  cur_buttons,
	input  wire logic [3:0]               cur_h,
	input  wire logic [3:0]               cur_v,
	input  wire logic [3:0]               cur_dir,
	input  wire logic [15:0]              cur_peak,
	output logic                          take,
	output logic      [BUTTON_COUNT-1:0]  btn_nxt,
	output logic      [3:0]               h_nxt,
	output logic      [3:0]               v_nxt,
	output logic      [3:0]               dir_nxt,
	output logic      [15:0]              peak_nxt,
	output wire gpdir_pkg::res_t          res
);

	logic        pad_ok;
	logic        is_btn;
	logic        is_axis;
	logic        is_hat;
	logic [7:0]  boff;
	logic [7:0]  aoff;
	logic [8:0]  bdiff;
	logic        b_bad;
	logic [31:0] bit_wide;
	logic [BUTTON_COUNT-1:0] bmask;
	logic        odd;
	logic [16:0] vext;
	logic [16:0] mag;
	logic [15:0] peak_upd;
	logic        dead;
	logic        neg;
	logic        pos;
	logic [3:0]  h_axis;
	logic [3:0]  v_axis;
	logic        hat_ok;
	logic        bad;
	logic [31:0] btn_wide;

	assign pad_ok  = (32'(evt.pad) < PAD_COUNT) && cfg.connected_mask[evt.pad];
	assign is_btn  = (evt.action == gpdir_pkg::ACT_BUTTON);
	assign is_axis = (evt.action == gpdir_pkg::ACT_AXIS);
	assign is_hat  = (evt.action == gpdir_pkg::ACT_HAT);
	assign take    = pad_ok && (evt.action != gpdir_pkg::ACT_OTHER);

	assign boff = cfg.button_offsets[{evt.pad, 3'b000} +: 8];
	assign aoff = cfg.axis_offsets[{evt.pad, 3'b000} +: 8];

	// Button index relative to the pad's offset; the top bit is the sign.
	assign bdiff = {1'b0, evt.raw_index} - {1'b0, boff};
	assign b_bad = bdiff[8] || (32'(bdiff[7:0]) >= BUTTON_COUNT);

	// The first two buttons trade places.
	always_comb begin
		case (bdiff[4:0])
			5'd0:    bit_wide = 32'd2;
			5'd1:    bit_wide = 32'd1;
			default: bit_wide = 32'd1 << bdiff[4:0];
		endcase
	end
	assign bmask = bit_wide[BUTTON_COUNT-1:0];

	// Axis magnitude, peak tracking and dead zone of half the peak.
	assign odd      = evt.raw_index[0] ^ aoff[0];
	assign vext     = {evt.raw_value[15], evt.raw_value};
	assign mag      = evt.raw_value[15] ? (17'd0 - vext) : vext;
	assign peak_upd = (mag > {1'b0, cur_peak}) ? mag[15:0] : cur_peak;
	assign dead     = mag < {2'b00, peak_upd[15:1]};
	assign neg      = evt.raw_value[15] && !dead;
	assign pos      = !evt.raw_value[15] && (evt.raw_value != 16'sd0) && !dead;

	always_comb begin
		h_axis = cur_h;
		v_axis = cur_v;
		if (!odd) begin
			h_axis = neg ? gpdir_pkg::DIR_LEFT : pos ? gpdir_pkg::DIR_RIGHT : gpdir_pkg::DIR_NONE;
		end else begin
			v_axis = neg ? gpdir_pkg::DIR_UP : pos ? gpdir_pkg::DIR_DOWN : gpdir_pkg::DIR_NONE;
		end
	end

	assign hat_ok = !evt.raw_value[15] && (evt.raw_value[14:0] <= 15'd8);

	always_comb begin
		btn_nxt  = cur_buttons;
		h_nxt    = cur_h;
		v_nxt    = cur_v;
		dir_nxt  = cur_dir;
		peak_nxt = cur_peak;
		bad      = 1'b0;
		if (is_btn) begin
			if (b_bad) begin
				bad = 1'b1;
			end else if (evt.raw_value != 16'sd0) begin
				btn_nxt = cur_buttons | bmask;
			end else begin
				btn_nxt = cur_buttons & ~bmask;
			end
		end else if (is_axis) begin
			h_nxt    = h_axis;
			v_nxt    = v_axis;
			dir_nxt  = h_axis | v_axis;
			peak_nxt = peak_upd;
		end else if (is_hat) begin
			if (hat_ok) begin
				dir_nxt = gpdir_pkg::hat_dir(evt.raw_value[3:0]);
			end else begin
				bad = 1'b1;
			end
		end
	end

	assign btn_wide        = 32'(btn_nxt);
	assign res.pad_out     = evt.pad;
	assign res.button_bits = btn_wide[20:0];
	assign res.direction   = dir_nxt;
	assign res.bad_index   = bad;

endmodule

`default_nettype wire

@@ rtl/gamepad_event_to_direction_bits.sv @@
// Top level of the gamepad event decoder: input register, pad state, result register.
// Each event passes through the input register and then the result register; a result not yet taken stalls it.
// Throughput: one event per cycle while results are taken; the result register frees as its transfer completes.
// Events for unconnected pads and "other" events are consumed with no result.
// Reset (arst_n low) clears all pad state, the shared axis peak, the valid flags and the configuration.
// After reset no pad is connected, so every event is dropped until configured.
`default_nettype none

module gamepad_event_to_direction_bits #(
	parameter int PAD_COUNT    = 4,
	parameter int BUTTON_COUNT = 21
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Event input channel.
	input  wire logic                         evt_valid,
	output logic                              evt_ready,
	input  wire gpdir_pkg::evt_t              evt,
	// Result output channel.
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output gpdir_pkg::res_t                   res,
	// Configuration port.
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [gpdir_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);

	gpdir_pkg::cfg_t cfg;

	// Input stage: one event held while the decode works on it.
	logic            vld_s1;
	gpdir_pkg::evt_t evt_s1;

	// Pad state, one entry per pad, plus the peak shared by all pads.
	logic [BUTTON_COUNT-1:0] buttons_q [PAD_COUNT];
	logic [3:0]              horiz_q   [PAD_COUNT];
	logic [3:0]              vert_q    [PAD_COUNT];
	logic [3:0]              dir_q     [PAD_COUNT];
	logic [15:0]             peak_q;

	// State of the pad addressed by the event in the input stage.
	logic [BUTTON_COUNT-1:0] cur_buttons;
	logic [3:0]              cur_h;
	logic [3:0]              cur_v;
	logic [3:0]              cur_dir;

	logic                    take;
	logic [BUTTON_COUNT-1:0] btn_nxt;
	logic [3:0]              h_nxt;
	logic [3:0]              v_nxt;
	logic [3:0]              dir_nxt;
	logic [15:0]             peak_nxt;
	gpdir_pkg::res_t         dec_res;

	logic            advance;
	logic            res_valid_q;
	gpdir_pkg::res_t res_q;

	assign pready = 1'b1;

	gpdir_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Select the addressed pad's state. Pad numbers beyond the pad count match
	// no entry; the decode drops those events, so the zero default is never used.
	always_comb begin
		cur_buttons = '0;
		cur_h       = '0;
		cur_v       = '0;
		cur_dir     = '0;
		for (int p = 0; p < PAD_COUNT; p++) begin
			if (32'(evt_s1.pad) == p) begin
				cur_buttons = buttons_q[p];
				cur_h       = horiz_q[p];
				cur_v       = vert_q[p];
				cur_dir     = dir_q[p];
			end
		end
	end

	gpdir_decode #(
		.PAD_COUNT    (PAD_COUNT),
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_decode (
		.evt         (evt_s1),
		.cfg         (cfg),
		.cur_buttons (cur_buttons),
		.cur_h       (cur_h),
		.cur_v       (cur_v),
		.cur_dir     (cur_dir),
		.cur_peak    (peak_q),
		.take        (take),
		.btn_nxt     (btn_nxt),
		.h_nxt       (h_nxt),
		.v_nxt       (v_nxt),
		.dir_nxt     (dir_nxt),
		.peak_nxt    (peak_nxt),
		.res         (dec_res)
	);

	// The held event retires when it makes no result, or when the result
	// register is empty or is being emptied by a transfer in this cycle.
	// A new event enters whenever the input stage is empty or retiring, so
	// back-to-back events flow at one per cycle while results are taken.
	assign advance   = vld_s1 && (!take || !res_valid_q || res_ready);
	assign evt_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (evt_ready) begin
			vld_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			evt_s1 <= evt;
		end
	end

	// Pad state updates at the edge where the event retires, so the next
	// event in the input stage already sees them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			for (int p = 0; p < PAD_COUNT; p++) begin
				buttons_q[p] <= '0;
				horiz_q[p]   <= '0;
				vert_q[p]    <= '0;
				dir_q[p]     <= '0;
			end
		end else if (advance && take) begin
			peak_q <= peak_nxt;
			for (int p = 0; p < PAD_COUNT; p++) begin
				if (32'(evt_s1.pad) == p) begin
					buttons_q[p] <= btn_nxt;
					horiz_q[p]   <= h_nxt;
					vert_q[p]    <= v_nxt;
					dir_q[p]     <= dir_nxt;
				end
			end
		end
	end

	// Result register: loaded as the event retires, held until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && take) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && take) begin
			res_q <= dec_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The shared axis peak only ever grows.
	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= $past(peak_q))
		else $error("axis peak decreased");

	// A reported direction never points both ways on one axis.
	a_dir_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.direction[0] && res.direction[1]) &&
			!(res.direction[2] && res.direction[3]))
		else $error("direction reports opposite bits together");

	// An event that cannot retire stays in the input stage untouched.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(evt_s1))
		else $error("held event lost or changed in input stage");

endmodule

`default_nettype wire
